@@ hw/rtl/smbms_pkg.sv @@
// Shared types and codes for the SMBus master transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package smbms_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_STATUS  = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_START        = 4'd0,
    ST_REP_START    = 4'd1,
    ST_MT_ADDR_ACK  = 4'd2,
    ST_MT_ADDR_NACK = 4'd3,
    ST_MT_DATA_ACK  = 4'd4,
    ST_MT_DATA_NACK = 4'd5,
    ST_MR_ADDR_ACK  = 4'd6,
    ST_MR_ADDR_NACK = 4'd7,
    ST_MR_DATA_ACK  = 4'd8,
    ST_MR_DATA_NACK = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    CFG_TARGET_ADDRESS  = 2'd0,
    CFG_TX_LENGTH       = 2'd1,
    CFG_RX_LENGTH       = 2'd2,
    CFG_ACK_POLL_ENABLE = 2'd3
  } cfg_e;

  // One result of the sequencer; send_from_mem selects the transmit memory as byte source.
  typedef struct packed {
    logic       send_from_mem;
    logic [7:0] send_byte;
    logic       send_valid;
    logic       start_request;
    logic       stop_request;
    logic       ack_level;
    logic       bus_reset;
    logic [7:0] recv_byte;
    logic [7:0] recv_index;
    logic       recv_valid;
    logic       busy_flag;
  } result_t;

  // State updates requested by the decision logic.
  typedef struct packed {
    logic busy;
    logic read_not_write;
    logic clear_counts;
    logic inc_sent;
    logic inc_recv;
    logic mem_read;
    logic clear_cfg;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/smbus_master_transfer_sequencer.sv @@
// Top level of the SMBus master transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one command item per clock while results are taken and returns exactly
// one result per item, registered at acceptance. A new item is accepted whenever the
// result register is empty or its result is being taken in the same cycle, so
// a steady stream runs at one item per cycle. Transmit bytes live in a
// TX_DEPTH x 8 synchronous RAM: a load writes it at acceptance, and a data
// send reads it at acceptance so the byte arrives together with the result.
// Transmit slots must be loaded before they are sent. Configuration writes
// apply at the clock edge at which cfg_we_i is high; a timeout clears the
// transfer lengths and the ack polling enable.
module smbus_master_transfer_sequencer #(
  parameter int TX_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [3:0] status_code_i,
  input  wire logic [7:0] bus_rx_byte_i,
  input  wire logic [3:0] load_index_i,
  input  wire logic [7:0] load_value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] send_byte_o,
  output logic            send_valid_o,
  output logic            start_request_o,
  output logic            stop_request_o,
  output logic            ack_level_o,
  output logic            bus_reset_o,
  output logic      [7:0] recv_byte_o,
  output logic      [7:0] recv_index_o,
  output logic            recv_valid_o,
  output logic            busy_flag_o
);

  localparam int CW  = $clog2(TX_DEPTH + 1);
  localparam int AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int LIW = (AW > 4) ? AW : 4;

  smbms_pkg::result_t res;
  smbms_pkg::result_t res_q;
  smbms_pkg::ctl_t    ctl;

  logic          accept;
  logic          out_valid_q, out_valid_d;
  logic [6:0]    target_address_q, target_address_d;
  logic [4:0]    tx_length_q, tx_length_d;
  logic [7:0]    rx_length_q, rx_length_d;
  logic          ack_poll_enable_q, ack_poll_enable_d;
  logic [CW-1:0] sent_count_q, sent_count_d;
  logic [7:0]    received_count_q, received_count_d;
  logic          busy_q, busy_d;
  logic          read_not_write_q, read_not_write_d;
  logic [LIW-1:0] load_index_ext;
  logic          load_in_range;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_rdata;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  smbms_step #(
    .TX_DEPTH (TX_DEPTH)
  ) u_step (
    .cmd_i             (cmd_i),
    .status_code_i     (status_code_i),
    .bus_rx_byte_i     (bus_rx_byte_i),
    .target_address_i  (target_address_q),
    .tx_length_i       (tx_length_q),
    .rx_length_i       (rx_length_q),
    .ack_poll_enable_i (ack_poll_enable_q),
    .sent_count_i      (sent_count_q),
    .received_count_i  (received_count_q),
    .busy_i            (busy_q),
    .read_not_write_i  (read_not_write_q),
    .res_o             (res),
    .ctl_o             (ctl)
  );

  // drop loads beyond the buffer
  assign load_index_ext = LIW'(load_index_i);
  assign load_in_range  = {1'b0, load_index_ext} < (LIW + 1)'(TX_DEPTH);
  assign mem_we = accept && (cmd_i == smbms_pkg::CMD_LOAD) && load_in_range;
  assign mem_re = accept && ctl.mem_read;

  smbms_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_index_ext[AW-1:0]),
    .wdata_i (load_value_i),
    .re_i    (mem_re),
    .raddr_i (sent_count_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    sent_count_d     = sent_count_q;
    received_count_d = received_count_q;
    busy_d           = busy_q;
    read_not_write_d = read_not_write_q;
    if (accept) begin
      busy_d           = ctl.busy;
      read_not_write_d = ctl.read_not_write;
      if (ctl.clear_counts) begin
        sent_count_d     = '0;
        received_count_d = '0;
      end
      if (ctl.inc_sent) begin
        sent_count_d = sent_count_q + CW'(1);
      end
      if (ctl.inc_recv) begin
        received_count_d = received_count_q + 8'd1;
      end
    end
  end

  always_comb begin
    target_address_d  = target_address_q;
    tx_length_d       = tx_length_q;
    rx_length_d       = rx_length_q;
    ack_poll_enable_d = ack_poll_enable_q;
    if (accept && ctl.clear_cfg) begin
      tx_length_d       = '0;
      rx_length_d       = '0;
      ack_poll_enable_d = 1'b0;
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        smbms_pkg::CFG_TARGET_ADDRESS:  target_address_d  = cfg_data_i[6:0];
        smbms_pkg::CFG_TX_LENGTH:       tx_length_d       = cfg_data_i[4:0];
        smbms_pkg::CFG_RX_LENGTH:       rx_length_d       = cfg_data_i;
        smbms_pkg::CFG_ACK_POLL_ENABLE: ack_poll_enable_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      target_address_q  <= '0;
      tx_length_q       <= '0;
      rx_length_q       <= '0;
      ack_poll_enable_q <= 1'b0;
      sent_count_q      <= '0;
      received_count_q  <= '0;
      busy_q            <= 1'b0;
      read_not_write_q  <= 1'b0;
    end else begin
      out_valid_q       <= out_valid_d;
      target_address_q  <= target_address_d;
      tx_length_q       <= tx_length_d;
      rx_length_q       <= rx_length_d;
      ack_poll_enable_q <= ack_poll_enable_d;
      sent_count_q      <= sent_count_d;
      received_count_q  <= received_count_d;
      busy_q            <= busy_d;
      read_not_write_q  <= read_not_write_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_byte_o     = res_q.send_from_mem ? mem_rdata : res_q.send_byte;
  assign send_valid_o    = res_q.send_valid;
  assign start_request_o = res_q.start_request;
  assign stop_request_o  = res_q.stop_request;
  assign ack_level_o     = res_q.ack_level;
  assign bus_reset_o     = res_q.bus_reset;
  assign recv_byte_o     = res_q.recv_byte;
  assign recv_index_o    = res_q.recv_index;
  assign recv_valid_o    = res_q.recv_valid;
  assign busy_flag_o     = res_q.busy_flag;

  a_busy_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (busy_flag_o == busy_q))
    else $error("busy flag of the shown result differs from the busy state");

  a_reset_is_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bus_reset_o) |->
      (!send_valid_o && !recv_valid_o && !start_request_o && !stop_request_o && !busy_flag_o))
    else $error("bus reset shown together with another bus action");

  a_sent_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_count_q <= CW'(TX_DEPTH))
    else $error("sent count ran past the transmit buffer");

  a_timeout_clears_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == smbms_pkg::CMD_TIMEOUT) && !cfg_we_i) |=>
      (tx_length_q == '0 && rx_length_q == '0 && !ack_poll_enable_q))
    else $error("timeout did not clear the transfer settings");

  a_mem_read_for_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.send_from_mem) |-> send_valid_o)
    else $error("memory byte selected without a send");

endmodule

`default_nettype wire

@@ hw/rtl/smbms_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module smbms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/smbms_step.sv @@
// Decision logic: result and state updates for one command item.
`timescale 1ns / 1ps
`default_nettype none

module smbms_step #(
  parameter int TX_DEPTH = 16,
  localparam int CW = $clog2(TX_DEPTH + 1),
  localparam int LW = (CW > 5) ? CW : 5
) (
  input  wire logic [1:0]    cmd_i,
  input  wire logic [3:0]    status_code_i,
  input  wire logic [7:0]    bus_rx_byte_i,
  input  wire logic [6:0]    target_address_i,
  input  wire logic [4:0]    tx_length_i,
  input  wire logic [7:0]    rx_length_i,
  input  wire logic          ack_poll_enable_i,
  input  wire logic [CW-1:0] sent_count_i,
  input  wire logic [7:0]    received_count_i,
  input  wire logic          busy_i,
  input  wire logic          read_not_write_i,
  output smbms_pkg::result_t res_o,
  output smbms_pkg::ctl_t    ctl_o
);

  logic [LW-1:0] tx_ext;
  logic [LW-1:0] depth_ext;
  logic [LW-1:0] txn;
  logic          more_tx;
  logic          more_rx;
  logic          ack_next;

  assign tx_ext    = LW'(tx_length_i);
  assign depth_ext = LW'(TX_DEPTH);
  assign txn       = (tx_ext < depth_ext) ? tx_ext : depth_ext;
  assign more_tx   = LW'(sent_count_i) < txn;
  assign more_rx   = received_count_i < rx_length_i;
  // NACK the byte at index rx_length-1
  assign ack_next  = ({1'b0, received_count_i} + 9'd2) < {1'b0, rx_length_i};

  always_comb begin
    logic fail;
    fail  = 1'b0;
    res_o = '0;
    ctl_o = '0;
    ctl_o.busy           = busy_i;
    ctl_o.read_not_write = read_not_write_i;

    unique case (cmd_i)
      smbms_pkg::CMD_LOAD: begin
      end
      smbms_pkg::CMD_START: begin
        if (!busy_i) begin
          if (txn != '0) begin
            ctl_o.read_not_write = 1'b0;
            ctl_o.busy           = 1'b1;
            res_o.start_request  = 1'b1;
          end else if (rx_length_i != 8'd0) begin
            ctl_o.read_not_write = 1'b1;
            ctl_o.busy           = 1'b1;
            res_o.start_request  = 1'b1;
          end
        end
      end
      smbms_pkg::CMD_TIMEOUT: begin
        res_o.bus_reset = 1'b1;
        ctl_o.busy      = 1'b0;
        ctl_o.clear_cfg = 1'b1;
      end
      smbms_pkg::CMD_STATUS: begin
        unique case (status_code_i) inside
          smbms_pkg::ST_START: begin
            ctl_o.clear_counts = 1'b1;
            res_o.send_byte    = {target_address_i, read_not_write_i};
            res_o.send_valid   = 1'b1;
          end
          smbms_pkg::ST_REP_START: begin
            res_o.send_byte  = {target_address_i, read_not_write_i};
            res_o.send_valid = 1'b1;
          end
          smbms_pkg::ST_MT_ADDR_ACK: begin
            if (more_tx) begin
              res_o.send_from_mem = 1'b1;
              res_o.send_valid    = 1'b1;
              ctl_o.mem_read      = 1'b1;
              ctl_o.inc_sent      = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          smbms_pkg::ST_MT_ADDR_NACK, smbms_pkg::ST_MR_ADDR_NACK: begin
            if (ack_poll_enable_i) begin
              res_o.stop_request  = 1'b1;
              res_o.start_request = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          smbms_pkg::ST_MT_DATA_ACK: begin
            if (more_tx) begin
              res_o.send_from_mem = 1'b1;
              res_o.send_valid    = 1'b1;
              ctl_o.mem_read      = 1'b1;
              ctl_o.inc_sent      = 1'b1;
            end else if (more_rx) begin
              // continue with a repeated start into the read phase
              ctl_o.read_not_write = 1'b1;
              res_o.start_request  = 1'b1;
            end else if (busy_i) begin
              res_o.stop_request = 1'b1;
              ctl_o.busy         = 1'b0;
            end
          end
          smbms_pkg::ST_MT_DATA_NACK: begin
            res_o.stop_request = 1'b1;
            ctl_o.busy         = 1'b0;
          end
          smbms_pkg::ST_MR_ADDR_ACK: begin
            res_o.ack_level = rx_length_i > 8'd1;
          end
          smbms_pkg::ST_MR_DATA_ACK: begin
            res_o.ack_level = ack_next;
            if (more_rx) begin
              res_o.recv_byte  = bus_rx_byte_i;
              res_o.recv_index = received_count_i;
              res_o.recv_valid = 1'b1;
              ctl_o.inc_recv   = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          smbms_pkg::ST_MR_DATA_NACK: begin
            if (more_rx) begin
              res_o.recv_byte  = bus_rx_byte_i;
              res_o.recv_index = received_count_i;
              res_o.recv_valid = 1'b1;
              ctl_o.inc_recv   = 1'b1;
            end
            res_o.stop_request = 1'b1;
            ctl_o.busy         = 1'b0;
          end
          default: begin
            fail = 1'b1;
          end
        endcase
        if (fail) begin
          res_o           = '0;
          res_o.bus_reset = 1'b1;
          ctl_o.busy      = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_o.busy_flag = ctl_o.busy;
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the SMBus master transfer sequencer.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD    = 8;
  localparam int TX_DEPTH      = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam logic [3:0] ST_OTHER = 4'hF;

  // Expected bus action for one command
  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       start_req;
    logic       stop_req;
    logic       ack_level;
    logic       bus_reset;
    logic [7:0] recv_byte;
    logic [7:0] recv_index;
    logic       recv_valid;
    logic       busy_flag;
  } bus_action_t;

  class action_scoreboard;
    bit [6:0]    target_addr;
    bit [4:0]    tx_len;
    bit [7:0]    rx_len;
    bit          poll_en;
    bit [7:0]    tx_bytes[TX_DEPTH];
    bit [4:0]    sent_cnt;
    bit [7:0]    recv_cnt;
    bit          busy;
    bit          reading;
    bus_action_t expected_actions[$];
    int          mismatches;
    int          actions_checked;

    function void clear_state();
      target_addr = '0; tx_len = '0; rx_len = '0; poll_en = 1'b0;
      sent_cnt = '0; recv_cnt = '0; busy = 1'b0; reading = 1'b0;
      mismatches = 0; actions_checked = 0;
      expected_actions.delete();
    endfunction

    function void set_register(smbms_pkg::cfg_e idx, logic [7:0] value);
      case (idx)
        smbms_pkg::CFG_TARGET_ADDRESS:  target_addr = value[6:0];
        smbms_pkg::CFG_TX_LENGTH:       tx_len      = value[4:0];
        smbms_pkg::CFG_RX_LENGTH:       rx_len      = value;
        smbms_pkg::CFG_ACK_POLL_ENABLE: poll_en     = value[0];
        default: ;
      endcase
    endfunction

    function bus_action_t predict_action(logic [1:0] cmd, logic [3:0] st, logic [7:0] rxb,
                                         logic [3:0] li, logic [7:0] lv);
      bus_action_t a;
      int          txn;
      int          idx;
      bit          fail;
      a    = '0;
      fail = 1'b0;
      txn  = (int'(tx_len) > TX_DEPTH) ? TX_DEPTH : int'(tx_len);
      idx  = int'(recv_cnt);
      case (cmd)
        smbms_pkg::CMD_LOAD: tx_bytes[li] = lv;
        smbms_pkg::CMD_START: begin
          if (!busy) begin
            if (txn > 0) begin
              reading = 1'b0; busy = 1'b1; a.start_req = 1'b1;
            end else if (rx_len > 0) begin
              reading = 1'b1; busy = 1'b1; a.start_req = 1'b1;
            end
          end
        end
        smbms_pkg::CMD_TIMEOUT: begin
          a.bus_reset = 1'b1; busy = 1'b0;
          tx_len = '0; rx_len = '0; poll_en = 1'b0;
        end
        default: begin
          case (st) inside
            smbms_pkg::ST_START: begin
              sent_cnt = '0; recv_cnt = '0;
              a.send_byte = {target_addr, reading}; a.send_valid = 1'b1;
            end
            smbms_pkg::ST_REP_START: begin
              a.send_byte = {target_addr, reading}; a.send_valid = 1'b1;
            end
            smbms_pkg::ST_MT_ADDR_ACK: begin
              if (int'(sent_cnt) < txn) begin
                a.send_byte = tx_bytes[sent_cnt[3:0]]; a.send_valid = 1'b1; sent_cnt++;
              end else fail = 1'b1;
            end
            smbms_pkg::ST_MT_ADDR_NACK, smbms_pkg::ST_MR_ADDR_NACK: begin
              if (poll_en) begin
                a.stop_req = 1'b1; a.start_req = 1'b1;
              end else fail = 1'b1;
            end
            smbms_pkg::ST_MT_DATA_ACK: begin
              if (int'(sent_cnt) < txn) begin
                a.send_byte = tx_bytes[sent_cnt[3:0]]; a.send_valid = 1'b1; sent_cnt++;
              end else if (recv_cnt < rx_len) begin
                reading = 1'b1; a.start_req = 1'b1;
              end else if (busy) begin
                a.stop_req = 1'b1; busy = 1'b0;
              end
            end
            smbms_pkg::ST_MT_DATA_NACK: begin
              a.stop_req = 1'b1; busy = 1'b0;
            end
            smbms_pkg::ST_MR_ADDR_ACK: a.ack_level = (rx_len > 1);
            smbms_pkg::ST_MR_DATA_ACK: begin
              // NACK goes out with the last byte, so ACK only while two or more remain
              a.ack_level = (idx + 2 < int'(rx_len));
              if (idx < int'(rx_len)) begin
                a.recv_byte = rxb; a.recv_index = idx[7:0]; a.recv_valid = 1'b1;
                recv_cnt = idx[7:0] + 8'd1;
              end else fail = 1'b1;
            end
            smbms_pkg::ST_MR_DATA_NACK: begin
              if (idx < int'(rx_len)) begin
                a.recv_byte = rxb; a.recv_index = idx[7:0]; a.recv_valid = 1'b1;
                recv_cnt = idx[7:0] + 8'd1;
              end
              a.stop_req = 1'b1; busy = 1'b0;
            end
            default: fail = 1'b1;
          endcase
          if (fail) begin
            a = '0; a.bus_reset = 1'b1; busy = 1'b0;
          end
        end
      endcase
      a.busy_flag = busy;
      return a;
    endfunction

    function void note_command(logic [1:0] cmd, logic [3:0] st, logic [7:0] rxb,
                               logic [3:0] li, logic [7:0] lv);
      expected_actions.push_back(predict_action(cmd, st, rxb, li, lv));
    endfunction

    function string describe(bus_action_t a);
      return $sformatf({"send %02h v%0b sta %0b sto %0b ack %0b rst %0b ",
                        "recv %02h@%0d v%0b busy %0b"},
                       a.send_byte, a.send_valid, a.start_req, a.stop_req, a.ack_level,
                       a.bus_reset, a.recv_byte, a.recv_index, a.recv_valid, a.busy_flag);
    endfunction

    function void check_result(bus_action_t got);
      bus_action_t want;
      actions_checked++;
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: %s", $realtime, describe(got));
        return;
      end
      want = expected_actions.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $realtime, describe(want), describe(got));
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] cmd_i;
  logic [3:0] status_code_i;
  logic [7:0] bus_rx_byte_i;
  logic [3:0] load_index_i;
  logic [7:0] load_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] send_byte_o;
  logic       send_valid_o;
  logic       start_request_o;
  logic       stop_request_o;
  logic       ack_level_o;
  logic       bus_reset_o;
  logic [7:0] recv_byte_o;
  logic [7:0] recv_index_o;
  logic       recv_valid_o;
  logic       busy_flag_o;

  action_scoreboard bus_sb;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  settings_used = 0;
  int  burst_left  = 0;
  bit  noisy       = 1'b0;
  bit  rx_hold_req = 1'b0;
  int  cfg_tx, cfg_rx;
  bit  cfg_poll;

  smbus_master_transfer_sequencer #(
    .TX_DEPTH(TX_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .status_code_i  (status_code_i),
    .bus_rx_byte_i  (bus_rx_byte_i),
    .load_index_i   (load_index_i),
    .load_value_i   (load_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .send_byte_o    (send_byte_o),
    .send_valid_o   (send_valid_o),
    .start_request_o(start_request_o),
    .stop_request_o (stop_request_o),
    .ack_level_o    (ack_level_o),
    .bus_reset_o    (bus_reset_o),
    .recv_byte_o    (recv_byte_o),
    .recv_index_o   (recv_index_o),
    .recv_valid_o   (recv_valid_o),
    .busy_flag_o    (busy_flag_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, bus_sb.expected_actions.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    bus_action_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = '{send_byte_o, send_valid_o, start_request_o, stop_request_o, ack_level_o,
                 bus_reset_o, recv_byte_o, recv_index_o, recv_valid_o, busy_flag_o};
        bus_sb.check_result(seen);
      end
      if (in_valid_i && in_ready_o)
        bus_sb.note_command(cmd_i, status_code_i, bus_rx_byte_i, load_index_i, load_value_i);
    end
  end

  // Receiver: switch between stall patterns, and hold off completely on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [3:0] st, logic [7:0] rxb,
                           logic [3:0] li, logic [7:0] lv);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    status_code_i <= st;
    bus_rx_byte_i <= rxb;
    load_index_i  <= li;
    load_value_i  <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_noise();
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(0, 19);
    if (r < 13)
      cmd = smbms_pkg::CMD_STATUS;
    else if (r < 16)
      cmd = smbms_pkg::CMD_LOAD;
    else if (r < 19)
      cmd = smbms_pkg::CMD_START;
    else
      cmd = smbms_pkg::CMD_TIMEOUT;
    send_item(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_status(logic [3:0] st);
    if (noisy && $urandom_range(0, 39) == 0) send_noise();
    if (noisy && $urandom_range(0, 19) == 0) send_noise();
    else send_item(smbms_pkg::CMD_STATUS, st, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    send_item(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(smbms_pkg::cfg_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    bus_sb.set_register(idx, value);
  endtask

  task automatic configure(logic [6:0] addr, int tx, int rx, bit poll);
    cfg_tx = tx; cfg_rx = rx; cfg_poll = poll;
    write_reg(smbms_pkg::CFG_TARGET_ADDRESS, {1'b0, addr});
    write_reg(smbms_pkg::CFG_TX_LENGTH, tx[7:0]);
    write_reg(smbms_pkg::CFG_RX_LENGTH, rx[7:0]);
    write_reg(smbms_pkg::CFG_ACK_POLL_ENABLE, {7'd0, poll});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Hold the sender off until every expected result has been taken
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (bus_sb.expected_actions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One well-formed transfer for the current setting, with occasional detours
  task automatic run_transfer();
    int txn;
    txn = (cfg_tx > TX_DEPTH) ? TX_DEPTH : cfg_tx;
    send_cmd(smbms_pkg::CMD_START);
    if (txn == 0 && cfg_rx == 0) return;
    send_status(smbms_pkg::ST_START);
    if (txn > 0) begin
      while (cfg_poll && $urandom_range(0, 3) == 0) begin
        send_status(smbms_pkg::ST_MT_ADDR_NACK);
        send_status(smbms_pkg::ST_START);
      end
      send_status(smbms_pkg::ST_MT_ADDR_ACK);
      for (int i = 0; i < txn; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          send_status(smbms_pkg::ST_MT_DATA_NACK);
          return;
        end
        send_status(smbms_pkg::ST_MT_DATA_ACK);
      end
      if (cfg_rx > 0) send_status(smbms_pkg::ST_REP_START);
    end
    if (cfg_rx > 0) begin
      while (cfg_poll && $urandom_range(0, 3) == 0) begin
        send_status(smbms_pkg::ST_MR_ADDR_NACK);
        send_status(smbms_pkg::ST_START);
      end
      send_status(smbms_pkg::ST_MR_ADDR_ACK);
      repeat (cfg_rx - 1) send_status(smbms_pkg::ST_MR_DATA_ACK);
      // now and then overrun the read bound
      if ($urandom_range(0, 7) == 0) send_status(smbms_pkg::ST_MR_DATA_ACK);
      send_status(smbms_pkg::ST_MR_DATA_NACK);
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         random_start;
    int         r;
    logic [6:0] addr;
    int         tx, rx;
    bus_sb = new();
    bus_sb.clear_state();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = '0;
    status_code_i = '0;
    bus_rx_byte_i = '0;
    load_index_i  = '0;
    load_value_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fill every transmit slot, then one write-then-read with the odd cases
    configure(7'h7F, 1, 2, 1'b1);
    for (int i = 0; i < TX_DEPTH; i++)
      send_item(smbms_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                i[3:0],
                (i == 0) ? 8'h00 : (i == TX_DEPTH - 1) ? 8'hFF : 8'($urandom_range(0, 255)));
    send_cmd(smbms_pkg::CMD_START);
    send_status(smbms_pkg::ST_START);
    send_status(smbms_pkg::ST_MT_ADDR_NACK);
    send_status(smbms_pkg::ST_START);
    send_cmd(smbms_pkg::CMD_START);
    send_status(smbms_pkg::ST_MT_ADDR_ACK);
    send_status(smbms_pkg::ST_MT_DATA_ACK);
    send_status(smbms_pkg::ST_REP_START);
    send_status(smbms_pkg::ST_MR_ADDR_ACK);
    send_item(smbms_pkg::CMD_STATUS, smbms_pkg::ST_MR_DATA_ACK, 8'hFF, 4'h0, 8'h00);
    send_item(smbms_pkg::CMD_STATUS, smbms_pkg::ST_MR_DATA_NACK, 8'h00, 4'hF, 8'hFF);
    send_status(ST_OTHER);
    send_cmd(smbms_pkg::CMD_TIMEOUT);
    send_cmd(smbms_pkg::CMD_START);

    // Random phases: new setting, up to two loads, then one to four transfers
    noisy = 1'b1;
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) configure(7'h7F, TX_DEPTH, 255, 1'b1);
      else if (phase == 1) configure(7'h00, 0, 1, 1'b0);
      else begin
        r = $urandom_range(0, 5);
        addr = (r == 0) ? 7'h00 : (r == 1) ? 7'h7F : 7'($urandom_range(0, 127));
        tx = ($urandom_range(0, 3) == 0) ? TX_DEPTH : $urandom_range(0, 6);
        rx = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
        configure(addr, tx, rx, 1'($urandom_range(0, 1)));
      end
      if (phase == 3) rx_hold_req = 1'b1;
      repeat ($urandom_range(0, 2))
        send_item(smbms_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 4)) run_transfer();
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bus_sb.expected_actions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d commands across %0d register settings and %0d random phases",
             items_sent, settings_used, phase);
    $display("Checked %0d results, %0d mismatches", bus_sb.actions_checked, bus_sb.mismatches);
    if (bus_sb.mismatches == 0 && bus_sb.expected_actions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/smbms_pkg.sv
hw/rtl/smbms_ram.sv
hw/rtl/smbms_step.sv
hw/rtl/smbus_master_transfer_sequencer.sv
tb/tb.sv
